// ===== rtl/core/smfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smfp_pkg
// Shared types and codes of the MIDI file track parser.
// ----------------------------------------------------------------------------
package smfp_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_CHANNEL = 3'd0;
    localparam logic [2:0] KIND_META    = 3'd1;
    localparam logic [2:0] KIND_SYSEX   = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD = 3'd3;
    localparam logic [2:0] KIND_FILE    = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_HEADER    = 3'd1;
    localparam logic [2:0] ERR_SMPTE     = 3'd2;
    localparam logic [2:0] ERR_TRACK_ID  = 3'd3;
    localparam logic [2:0] ERR_META_LEN  = 3'd4;
    localparam logic [2:0] ERR_STATUS    = 3'd5;
    localparam logic [2:0] ERR_VLQ       = 3'd6;

    localparam logic [31:0] ID_MTHD = 32'h4D546864;
    localparam logic [31:0] ID_MTRK = 32'h4D54726B;

    localparam int DATA_W = 136;

    // Parser phases, one-hot.
    typedef enum logic [16:0] {
        PH_HDR_ID    = 17'h00001,
        PH_HDR_LEN   = 17'h00002,
        PH_HDR_FMT   = 17'h00004,
        PH_HDR_NTRK  = 17'h00008,
        PH_HDR_DIV   = 17'h00010,
        PH_TRK_ID    = 17'h00020,
        PH_TRK_LEN   = 17'h00040,
        PH_DELTA     = 17'h00080,
        PH_STATUS    = 17'h00100,
        PH_DATA1     = 17'h00200,
        PH_DATA2     = 17'h00400,
        PH_META_TYPE = 17'h00800,
        PH_META_LEN  = 17'h01000,
        PH_SYSEX_LEN = 17'h02000,
        PH_BODY      = 17'h04000,
        PH_HALT      = 17'h08000,
        PH_DONE      = 17'h10000
    } phase_t;

    // One result item.
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] track_index;
        logic [27:0] delta_ticks;
        logic [7:0]  status_byte;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [7:0]  meta_kind;
        logic [27:0] body_length;
        logic [7:0]  body_byte;
        logic [2:0]  error_code;
        logic [14:0] ticks_per_quarter;
        logic        file_done;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/smfp_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smfp_parse
// Parser state and the single-pass logic that handles one file byte.
// ----------------------------------------------------------------------------
module smfp_parse (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_first,
    output logic                 res_valid,
    output smfp_pkg::result_t    res
);

    smfp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] tracks_reg, tracks_next;
    logic [15:0] track_reg, track_next;
    logic [31:0] chunk_reg, chunk_next;
    logic [7:0]  run_reg, run_next;
    logic [7:0]  pstat_reg, pstat_next;
    logic [7:0]  pd1_reg, pd1_next;
    logic [7:0]  pmeta_reg, pmeta_next;
    logic [27:0] pdelta_reg, pdelta_next;
    logic [27:0] bleft_reg, bleft_next;
    logic [14:0] div_reg, div_next;

    // Next-state and result logic.
    always_comb begin
        smfp_pkg::phase_t ph;
        logic [2:0]  cnt;
        logic [31:0] acc;
        logic [15:0] tracks;
        logic [15:0] track;
        logic [31:0] chunk;
        logic [7:0]  run;
        logic [2:0]  cnt_g;
        logic [31:0] acc_g;
        logic [31:0] acc_v;
        logic        vlq_end;
        logic        vlq_over;
        logic        do_end;
        logic        len_ok;
        logic [27:0] bl;

        // A first byte restarts from the reset state.
        ph     = in_first ? smfp_pkg::PH_HDR_ID : phase_reg;
        cnt    = in_first ? 3'd0 : cnt_reg;
        acc    = in_first ? 32'd0 : acc_reg;
        tracks = in_first ? 16'd0 : tracks_reg;
        track  = in_first ? 16'd0 : track_reg;
        chunk  = in_first ? 32'd0 : chunk_reg;
        run    = in_first ? 8'd0 : run_reg;

        phase_next  = ph;
        cnt_next    = cnt;
        acc_next    = acc;
        tracks_next = tracks;
        track_next  = track;
        chunk_next  = chunk;
        run_next    = run;
        pstat_next  = in_first ? 8'd0 : pstat_reg;
        pd1_next    = in_first ? 8'd0 : pd1_reg;
        pmeta_next  = in_first ? 8'd0 : pmeta_reg;
        pdelta_next = in_first ? 28'd0 : pdelta_reg;
        bleft_next  = in_first ? 28'd0 : bleft_reg;
        div_next    = in_first ? 15'd0 : div_reg;

        res_valid       = 1'b0;
        res             = '0;
        res.track_index = track;
        do_end          = 1'b0;
        len_ok          = 1'b1;
        bl              = '0;

        // Header word and variable-length field assembly.
        cnt_g    = cnt + 3'd1;
        acc_g    = {acc[23:0], in_byte};
        acc_v    = {4'd0, acc[20:0], in_byte[6:0]};
        vlq_end  = !in_byte[7];
        vlq_over = in_byte[7] && (cnt_g >= 3'd4);

        // Track bytes count down the chunk length.
        if ((ph == smfp_pkg::PH_DELTA || ph == smfp_pkg::PH_STATUS ||
             ph == smfp_pkg::PH_DATA1 || ph == smfp_pkg::PH_DATA2 ||
             ph == smfp_pkg::PH_META_TYPE || ph == smfp_pkg::PH_META_LEN ||
             ph == smfp_pkg::PH_SYSEX_LEN || ph == smfp_pkg::PH_BODY) &&
            chunk != 32'd0) begin
            chunk_next = chunk - 32'd1;
        end

        case (ph)
            smfp_pkg::PH_HDR_ID: begin
                cnt_next = cnt_g;
                acc_next = acc_g;
                if (cnt_g >= 3'd4) begin
                    if (acc_g != smfp_pkg::ID_MTHD) begin
                        res_valid      = 1'b1;
                        res.kind       = smfp_pkg::KIND_ERROR;
                        res.error_code = smfp_pkg::ERR_HEADER;
                        phase_next     = smfp_pkg::PH_HALT;
                    end else begin
                        phase_next = smfp_pkg::PH_HDR_LEN;
                        cnt_next   = 3'd0;
                        acc_next   = 32'd0;
                    end
                end
            end
            smfp_pkg::PH_HDR_LEN: begin
                cnt_next = cnt_g;
                acc_next = acc_g;
                if (cnt_g >= 3'd4) begin
                    if (acc_g != 32'd6) begin
                        res_valid      = 1'b1;
                        res.kind       = smfp_pkg::KIND_ERROR;
                        res.error_code = smfp_pkg::ERR_HEADER;
                        phase_next     = smfp_pkg::PH_HALT;
                    end else begin
                        phase_next = smfp_pkg::PH_HDR_FMT;
                        cnt_next   = 3'd0;
                        acc_next   = 32'd0;
                    end
                end
            end
            smfp_pkg::PH_HDR_FMT: begin
                cnt_next = cnt_g;
                acc_next = acc_g;
                if (cnt_g >= 3'd2) begin
                    phase_next = smfp_pkg::PH_HDR_NTRK;
                    cnt_next   = 3'd0;
                    acc_next   = 32'd0;
                end
            end
            smfp_pkg::PH_HDR_NTRK: begin
                cnt_next = cnt_g;
                acc_next = acc_g;
                if (cnt_g >= 3'd2) begin
                    tracks_next = acc_g[15:0];
                    phase_next  = smfp_pkg::PH_HDR_DIV;
                    cnt_next    = 3'd0;
                    acc_next    = 32'd0;
                end
            end
            smfp_pkg::PH_HDR_DIV: begin
                cnt_next = cnt_g;
                acc_next = acc_g;
                if (cnt_g >= 3'd2) begin
                    res_valid = 1'b1;
                    if (acc_g[15]) begin
                        res.kind       = smfp_pkg::KIND_ERROR;
                        res.error_code = smfp_pkg::ERR_SMPTE;
                        phase_next     = smfp_pkg::PH_HALT;
                    end else begin
                        div_next              = acc_g[14:0];
                        res.kind              = smfp_pkg::KIND_FILE;
                        res.ticks_per_quarter = acc_g[14:0];
                        if (tracks == 16'd0) begin
                            phase_next    = smfp_pkg::PH_DONE;
                            res.file_done = 1'b1;
                        end else begin
                            phase_next = smfp_pkg::PH_TRK_ID;
                            cnt_next   = 3'd0;
                            acc_next   = 32'd0;
                        end
                    end
                end
            end
            smfp_pkg::PH_TRK_ID: begin
                cnt_next = cnt_g;
                acc_next = acc_g;
                if (cnt_g >= 3'd4) begin
                    if (acc_g != smfp_pkg::ID_MTRK) begin
                        res_valid      = 1'b1;
                        res.kind       = smfp_pkg::KIND_ERROR;
                        res.error_code = smfp_pkg::ERR_TRACK_ID;
                        phase_next     = smfp_pkg::PH_HALT;
                    end else begin
                        phase_next = smfp_pkg::PH_TRK_LEN;
                        cnt_next   = 3'd0;
                        acc_next   = 32'd0;
                    end
                end
            end
            smfp_pkg::PH_TRK_LEN: begin
                cnt_next = cnt_g;
                acc_next = acc_g;
                if (cnt_g >= 3'd4) begin
                    chunk_next = acc_g;
                    run_next   = 8'd0;
                    do_end     = 1'b1;
                end
            end
            smfp_pkg::PH_DELTA: begin
                cnt_next = cnt_g;
                acc_next = acc_v;
                if (vlq_over) begin
                    res_valid      = 1'b1;
                    res.kind       = smfp_pkg::KIND_ERROR;
                    res.error_code = smfp_pkg::ERR_VLQ;
                    phase_next     = smfp_pkg::PH_HALT;
                end else if (vlq_end) begin
                    pdelta_next = acc_v[27:0];
                    phase_next  = smfp_pkg::PH_STATUS;
                end
            end
            smfp_pkg::PH_STATUS: begin
                if (!in_byte[7]) begin
                    // Running status: reuse the last channel status.
                    if (run == 8'd0) begin
                        res_valid      = 1'b1;
                        res.kind       = smfp_pkg::KIND_ERROR;
                        res.error_code = smfp_pkg::ERR_STATUS;
                        phase_next     = smfp_pkg::PH_HALT;
                    end else begin
                        pstat_next = run;
                        pd1_next   = in_byte;
                        if (run[7:4] != 4'hC && run[7:4] != 4'hD) begin
                            phase_next = smfp_pkg::PH_DATA2;
                        end else begin
                            res_valid       = 1'b1;
                            res.kind        = smfp_pkg::KIND_CHANNEL;
                            res.delta_ticks = pdelta_next;
                            res.status_byte = run;
                            res.first_data  = in_byte;
                            res.second_data = 8'hFF;
                            do_end          = 1'b1;
                        end
                    end
                end else if (in_byte < 8'hF0) begin
                    run_next   = in_byte;
                    pstat_next = in_byte;
                    phase_next = smfp_pkg::PH_DATA1;
                end else if (in_byte == 8'hFF) begin
                    run_next   = 8'd0;
                    pstat_next = in_byte;
                    phase_next = smfp_pkg::PH_META_TYPE;
                end else if (in_byte == 8'hF0 || in_byte == 8'hF7) begin
                    run_next   = 8'd0;
                    pstat_next = in_byte;
                    pmeta_next = 8'd0;
                    phase_next = smfp_pkg::PH_SYSEX_LEN;
                    cnt_next   = 3'd0;
                    acc_next   = 32'd0;
                end else begin
                    res_valid      = 1'b1;
                    res.kind       = smfp_pkg::KIND_ERROR;
                    res.error_code = smfp_pkg::ERR_STATUS;
                    phase_next     = smfp_pkg::PH_HALT;
                end
            end
            smfp_pkg::PH_DATA1: begin
                pd1_next = in_byte;
                if (pstat_next[7:4] != 4'hC && pstat_next[7:4] != 4'hD) begin
                    phase_next = smfp_pkg::PH_DATA2;
                end else begin
                    res_valid       = 1'b1;
                    res.kind        = smfp_pkg::KIND_CHANNEL;
                    res.delta_ticks = pdelta_next;
                    res.status_byte = pstat_next;
                    res.first_data  = in_byte;
                    res.second_data = 8'hFF;
                    do_end          = 1'b1;
                end
            end
            smfp_pkg::PH_DATA2: begin
                res_valid       = 1'b1;
                res.kind        = smfp_pkg::KIND_CHANNEL;
                res.delta_ticks = pdelta_next;
                res.status_byte = pstat_next;
                res.first_data  = pd1_next;
                res.second_data = in_byte;
                do_end          = 1'b1;
            end
            smfp_pkg::PH_META_TYPE: begin
                pmeta_next = in_byte;
                phase_next = smfp_pkg::PH_META_LEN;
                cnt_next   = 3'd0;
                acc_next   = 32'd0;
            end
            smfp_pkg::PH_META_LEN, smfp_pkg::PH_SYSEX_LEN: begin
                cnt_next = cnt_g;
                acc_next = acc_v;
                // Subtypes with a fixed length must match it.
                if (ph == smfp_pkg::PH_META_LEN) begin
                    case (pmeta_next)
                        8'h00:   len_ok = (acc_v == 32'd2);
                        8'h2F:   len_ok = (acc_v == 32'd0);
                        8'h51:   len_ok = (acc_v == 32'd3);
                        8'h54:   len_ok = (acc_v == 32'd5);
                        8'h58:   len_ok = (acc_v == 32'd4);
                        8'h59:   len_ok = (acc_v == 32'd2);
                        default: len_ok = 1'b1;
                    endcase
                end
                if (vlq_over) begin
                    res_valid      = 1'b1;
                    res.kind       = smfp_pkg::KIND_ERROR;
                    res.error_code = smfp_pkg::ERR_VLQ;
                    phase_next     = smfp_pkg::PH_HALT;
                end else if (vlq_end) begin
                    res_valid = 1'b1;
                    if (!len_ok) begin
                        res.kind       = smfp_pkg::KIND_ERROR;
                        res.error_code = smfp_pkg::ERR_META_LEN;
                        phase_next     = smfp_pkg::PH_HALT;
                    end else begin
                        res.kind        = (ph == smfp_pkg::PH_META_LEN) ?
                                          smfp_pkg::KIND_META : smfp_pkg::KIND_SYSEX;
                        res.delta_ticks = pdelta_next;
                        res.status_byte = pstat_next;
                        res.meta_kind   = (ph == smfp_pkg::PH_META_LEN) ?
                                          pmeta_next : 8'd0;
                        res.body_length = acc_v[27:0];
                        bleft_next      = acc_v[27:0];
                        if (acc_v[27:0] == 28'd0) begin
                            do_end = 1'b1;
                        end else begin
                            phase_next = smfp_pkg::PH_BODY;
                        end
                    end
                end
            end
            smfp_pkg::PH_BODY: begin
                bl              = (bleft_next != 28'd0) ? bleft_next - 28'd1 : 28'd0;
                bleft_next      = bl;
                res_valid       = 1'b1;
                res.kind        = smfp_pkg::KIND_PAYLOAD;
                res.delta_ticks = pdelta_next;
                res.status_byte = pstat_next;
                res.meta_kind   = (pstat_next == 8'hFF) ? pmeta_next : 8'd0;
                res.body_length = bl;
                res.body_byte   = in_byte;
                do_end          = (bl == 28'd0);
            end
            default: begin
            end
        endcase

        // Event boundary: next event, next chunk, or end of file.
        if (do_end) begin
            if (chunk_next != 32'd0) begin
                phase_next = smfp_pkg::PH_DELTA;
                cnt_next   = 3'd0;
                acc_next   = 32'd0;
            end else begin
                tracks_next = tracks - 16'd1;
                track_next  = track + 16'd1;
                if (tracks == 16'd1) begin
                    phase_next    = smfp_pkg::PH_DONE;
                    res.file_done = 1'b1;
                end else begin
                    phase_next = smfp_pkg::PH_TRK_ID;
                    cnt_next   = 3'd0;
                    acc_next   = 32'd0;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= smfp_pkg::PH_HDR_ID;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            tracks_reg <= '0;
            track_reg  <= '0;
            chunk_reg  <= '0;
            run_reg    <= '0;
            pstat_reg  <= '0;
            pd1_reg    <= '0;
            pmeta_reg  <= '0;
            pdelta_reg <= '0;
            bleft_reg  <= '0;
            div_reg    <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            acc_reg    <= acc_next;
            tracks_reg <= tracks_next;
            track_reg  <= track_next;
            chunk_reg  <= chunk_next;
            run_reg    <= run_next;
            pstat_reg  <= pstat_next;
            pd1_reg    <= pd1_next;
            pmeta_reg  <= pmeta_next;
            pdelta_reg <= pdelta_next;
            bleft_reg  <= bleft_next;
            div_reg    <= div_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/smfp_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smfp_out_reg
// Result register that holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module smfp_out_reg (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire logic                 res_valid,
    input  wire smfp_pkg::result_t    res,
    output logic                      free,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output smfp_pkg::result_t         m_res
);

    logic              valid_reg, valid_next;
    smfp_pkg::result_t res_reg;

    // The slot is free when empty or when its transaction completes now.
    assign free = !valid_reg || m_tready;

    always_comb begin
        if (load) begin
            valid_next = res_valid;
        end else begin
            valid_next = valid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (load && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule
`default_nettype wire

// ===== rtl/core/midi_file_track_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_file_track_parser
// Parses a Standard MIDI File fed one byte per transaction.
//
// The slave channel carries one file byte per transaction in s_tdata, with
// s_tuser set on the first byte of a file to restart parsing at the header.
// The master channel gives at most one result per byte: kind in m_tuser,
// the remaining fields in m_tdata, and m_tlast on the result that ends the
// file. Bytes that cause no result are absorbed silently.
// Each byte lands in an input register, is parsed in one pass of logic and
// its result is written to the result register, which drives m_tvalid.
// One byte is taken every cycle while the result register is empty or being
// read, so the throughput is one byte per cycle while the receiver keeps up.
// After reset the parser waits for the MThd header and both registers are
// empty. When the receiver holds m_tready low, the result waits, the input
// register fills, and s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module midi_file_track_parser (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // file_byte
    input  wire logic [0:0]                  s_tuser,   // first_of_file
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // m_tdata from bit 0: track_index, delta_ticks, status_byte, first_data,
    // second_data, meta_kind, body_length, body_byte, error_code,
    // ticks_per_quarter, zero fill.
    output logic [smfp_pkg::DATA_W-1:0]      m_tdata,
    output logic [2:0]                       m_tuser,   // kind
    output logic                             m_tlast    // file_done
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              in_first_reg;
    logic              step;
    logic              free;
    logic              res_valid;
    smfp_pkg::result_t res;
    smfp_pkg::result_t m_res;

    // An input byte moves on when the result register can take its result.
    assign step     = in_valid_reg && free;
    assign s_tready = !in_valid_reg || step;

    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else begin
            in_valid_next = in_valid_reg && !step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
        end
    end

    smfp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_byte   (in_byte_reg),
        .in_first  (in_first_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    smfp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step),
        .res_valid (res_valid),
        .res       (res),
        .free      (free),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_res     (m_res)
    );

    // Pack the result fields onto the stream.
    assign m_tdata = {6'd0, m_res.ticks_per_quarter, m_res.error_code, m_res.body_byte,
                      m_res.body_length, m_res.meta_kind, m_res.second_data,
                      m_res.first_data, m_res.status_byte, m_res.delta_ticks,
                      m_res.track_index};
    assign m_tuser = m_res.kind;
    assign m_tlast = m_res.file_done;

endmodule
`default_nettype wire

// ===== bench/midi_file_track_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_file_track_parser_test
// Self-checking bench for the MIDI file track parser.
//
// Builds MIDI files with random tracks, events and injected faults. It sends
// them byte by byte through the input stream and predicts each result with
// its own parser model. Every result transaction is checked field by field
// against the oldest prediction. Sender gaps and receiver stalls change over
// several phases of the run.
// ----------------------------------------------------------------------------
module midi_file_track_parser_test;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        bit [7:0] value;
        bit       first;
    } file_byte_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata = '0;
    logic [0:0]                    s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [smfp_pkg::DATA_W-1:0]   m_tdata;
    logic [2:0]                    m_tuser;
    logic                          m_tlast;

    file_byte_t         byte_stream[$];
    smfp_pkg::result_t  expected_results[$];
    bit [7:0]           track_body[$];
    bit [7:0]           last_channel_status;
    int                 bytes_total;
    int                 bytes_sent;
    int                 mismatch_count;
    int                 cycle_count;

    // Parser model state.
    smfp_pkg::phase_t p_phase;
    bit [2:0]    p_count;
    bit [31:0]   p_acc;
    bit [15:0]   p_tracks_left;
    bit [15:0]   p_track;
    bit [31:0]   p_chunk_left;
    bit [7:0]    p_running;
    bit [7:0]    p_status;
    bit [7:0]    p_first;
    bit [7:0]    p_meta;
    bit [27:0]   p_delta;
    bit [27:0]   p_body_left;
    bit [14:0]   p_division;

    midi_file_track_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic void start_field(smfp_pkg::phase_t ph);
        p_phase = ph;
        p_count = '0;
        p_acc   = '0;
    endfunction

    function automatic bit gather(bit [7:0] b, int n);
        p_acc   = {p_acc[23:0], b};
        p_count = p_count + 3'd1;
        return p_count >= n;
    endfunction

    // Returns 0 while more bytes follow, 1 when complete, 2 when overlong.
    function automatic int vlq_step(bit [7:0] b);
        p_acc   = {4'b0, p_acc[20:0], b[6:0]};
        p_count = p_count + 3'd1;
        if (!b[7])
            return 1;
        return (p_count >= 4) ? 2 : 0;
    endfunction

    // Closes an event; returns 1 when the whole file has ended.
    function automatic bit end_event();
        if (p_chunk_left != 0) begin
            start_field(smfp_pkg::PH_DELTA);
            return 1'b0;
        end
        p_tracks_left = p_tracks_left - 16'd1;
        p_track       = p_track + 16'd1;
        if (p_tracks_left == 0) begin
            p_phase = smfp_pkg::PH_DONE;
            return 1'b1;
        end
        start_field(smfp_pkg::PH_TRK_ID);
        return 1'b0;
    endfunction

    function automatic bit has_two_data(bit [7:0] s);
        return s[7:4] != 4'hC && s[7:4] != 4'hD;
    endfunction

    function automatic bit meta_length_ok(bit [7:0] k, bit [31:0] len);
        case (k)
            8'h00: return len == 2;
            8'h2F: return len == 0;
            8'h51: return len == 3;
            8'h54: return len == 5;
            8'h58: return len == 4;
            8'h59: return len == 2;
            default: return 1'b1;
        endcase
    endfunction

    function automatic void fail_with(ref smfp_pkg::result_t r, ref bit has,
                                      input bit [2:0] code);
        r.kind       = smfp_pkg::KIND_ERROR;
        r.error_code = code;
        p_phase      = smfp_pkg::PH_HALT;
        has          = 1'b1;
    endfunction

    function automatic void channel_result(ref smfp_pkg::result_t r, input bit [7:0] second);
        r.kind        = smfp_pkg::KIND_CHANNEL;
        r.delta_ticks = p_delta;
        r.status_byte = p_status;
        r.first_data  = p_first;
        r.second_data = second;
        r.file_done   = end_event();
    endfunction

    function automatic void body_header(ref smfp_pkg::result_t r, input bit [2:0] kind);
        r.kind        = kind;
        r.delta_ticks = p_delta;
        r.status_byte = p_status;
        r.meta_kind   = (kind == smfp_pkg::KIND_META) ? p_meta : 8'h00;
        r.body_length = p_acc[27:0];
        p_body_left   = p_acc[27:0];
        if (p_acc[27:0] == 0)
            r.file_done = end_event();
        else
            p_phase = smfp_pkg::PH_BODY;
    endfunction

    function automatic void parser_reset();
        start_field(smfp_pkg::PH_HDR_ID);
        p_tracks_left = '0;
        p_track       = '0;
        p_chunk_left  = '0;
        p_running     = '0;
        p_status      = '0;
        p_first       = '0;
        p_meta        = '0;
        p_delta       = '0;
        p_body_left   = '0;
        p_division    = '0;
    endfunction

    // Runs one file byte through the model and queues its result, if any.
    function automatic void predict_byte(bit [7:0] b, bit first);
        smfp_pkg::result_t r;
        bit      has;
        int      v;
        r   = '0;
        has = 1'b0;
        if (first)
            parser_reset();
        r.track_index = p_track;
        if (p_phase inside {smfp_pkg::PH_DELTA, smfp_pkg::PH_STATUS, smfp_pkg::PH_DATA1,
                            smfp_pkg::PH_DATA2, smfp_pkg::PH_META_TYPE,
                            smfp_pkg::PH_META_LEN, smfp_pkg::PH_SYSEX_LEN,
                            smfp_pkg::PH_BODY} && p_chunk_left != 0)
            p_chunk_left = p_chunk_left - 1;
        case (p_phase)
            smfp_pkg::PH_HDR_ID: begin
                if (gather(b, 4)) begin
                    if (p_acc != smfp_pkg::ID_MTHD) fail_with(r, has, smfp_pkg::ERR_HEADER);
                    else start_field(smfp_pkg::PH_HDR_LEN);
                end
            end
            smfp_pkg::PH_HDR_LEN: begin
                if (gather(b, 4)) begin
                    if (p_acc != 32'd6) fail_with(r, has, smfp_pkg::ERR_HEADER);
                    else start_field(smfp_pkg::PH_HDR_FMT);
                end
            end
            smfp_pkg::PH_HDR_FMT: begin
                if (gather(b, 2)) start_field(smfp_pkg::PH_HDR_NTRK);
            end
            smfp_pkg::PH_HDR_NTRK: begin
                if (gather(b, 2)) begin
                    p_tracks_left = p_acc[15:0];
                    start_field(smfp_pkg::PH_HDR_DIV);
                end
            end
            smfp_pkg::PH_HDR_DIV: begin
                if (gather(b, 2)) begin
                    if (p_acc[15]) begin
                        fail_with(r, has, smfp_pkg::ERR_SMPTE);
                    end else begin
                        p_division = p_acc[14:0];
                        has = 1'b1;
                        r.kind = smfp_pkg::KIND_FILE;
                        r.ticks_per_quarter = p_division;
                        if (p_tracks_left == 0) begin
                            p_phase = smfp_pkg::PH_DONE;
                            r.file_done = 1'b1;
                        end else begin
                            start_field(smfp_pkg::PH_TRK_ID);
                        end
                    end
                end
            end
            smfp_pkg::PH_TRK_ID: begin
                if (gather(b, 4)) begin
                    if (p_acc != smfp_pkg::ID_MTRK) fail_with(r, has, smfp_pkg::ERR_TRACK_ID);
                    else start_field(smfp_pkg::PH_TRK_LEN);
                end
            end
            smfp_pkg::PH_TRK_LEN: begin
                if (gather(b, 4)) begin
                    p_chunk_left = p_acc;
                    p_running = '0;
                    void'(end_event());
                end
            end
            smfp_pkg::PH_DELTA: begin
                v = vlq_step(b);
                if (v == 2) begin
                    fail_with(r, has, smfp_pkg::ERR_VLQ);
                end else if (v == 1) begin
                    p_delta = p_acc[27:0];
                    p_phase = smfp_pkg::PH_STATUS;
                end
            end
            smfp_pkg::PH_STATUS: begin
                if (!b[7]) begin
                    if (p_running == 0) begin
                        fail_with(r, has, smfp_pkg::ERR_STATUS);
                    end else begin
                        p_status = p_running;
                        p_first  = b;
                        if (has_two_data(p_status)) begin
                            p_phase = smfp_pkg::PH_DATA2;
                        end else begin
                            has = 1'b1;
                            channel_result(r, 8'hFF);
                        end
                    end
                end else if (b < 8'hF0) begin
                    p_running = b;
                    p_status  = b;
                    p_phase   = smfp_pkg::PH_DATA1;
                end else if (b == 8'hFF) begin
                    p_running = '0;
                    p_status  = b;
                    p_phase   = smfp_pkg::PH_META_TYPE;
                end else if (b == 8'hF0 || b == 8'hF7) begin
                    p_running = '0;
                    p_status  = b;
                    p_meta    = '0;
                    start_field(smfp_pkg::PH_SYSEX_LEN);
                end else begin
                    fail_with(r, has, smfp_pkg::ERR_STATUS);
                end
            end
            smfp_pkg::PH_DATA1: begin
                p_first = b;
                if (has_two_data(p_status)) begin
                    p_phase = smfp_pkg::PH_DATA2;
                end else begin
                    has = 1'b1;
                    channel_result(r, 8'hFF);
                end
            end
            smfp_pkg::PH_DATA2: begin
                has = 1'b1;
                channel_result(r, b);
            end
            smfp_pkg::PH_META_TYPE: begin
                p_meta = b;
                start_field(smfp_pkg::PH_META_LEN);
            end
            smfp_pkg::PH_META_LEN: begin
                v = vlq_step(b);
                if (v == 2) begin
                    fail_with(r, has, smfp_pkg::ERR_VLQ);
                end else if (v == 1) begin
                    if (!meta_length_ok(p_meta, p_acc)) begin
                        fail_with(r, has, smfp_pkg::ERR_META_LEN);
                    end else begin
                        has = 1'b1;
                        body_header(r, smfp_pkg::KIND_META);
                    end
                end
            end
            smfp_pkg::PH_SYSEX_LEN: begin
                v = vlq_step(b);
                if (v == 2) begin
                    fail_with(r, has, smfp_pkg::ERR_VLQ);
                end else if (v == 1) begin
                    has = 1'b1;
                    body_header(r, smfp_pkg::KIND_SYSEX);
                end
            end
            smfp_pkg::PH_BODY: begin
                if (p_body_left != 0)
                    p_body_left = p_body_left - 28'd1;
                has = 1'b1;
                r.kind        = smfp_pkg::KIND_PAYLOAD;
                r.delta_ticks = p_delta;
                r.status_byte = p_status;
                r.meta_kind   = (p_status == 8'hFF) ? p_meta : 8'h00;
                r.body_length = p_body_left;
                r.body_byte   = b;
                if (p_body_left == 0)
                    r.file_done = end_event();
            end
            default: ;
        endcase
        if (has)
            expected_results.insert(expected_results.size(), r);
    endfunction

    // ------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------
    function automatic void put_byte(bit [7:0] b, bit first = 1'b0);
        file_byte_t fb;
        fb.value = b;
        fb.first = first;
        byte_stream.insert(byte_stream.size(), fb);
    endfunction

    function automatic void put_word(bit [31:0] w, int n);
        for (int i = n - 1; i >= 0; i--)
            put_byte(w[8*i +: 8]);
    endfunction

    // Appends one byte to the current track body.
    function automatic void append_body(bit [7:0] b);
        track_body.insert(track_body.size(), b);
    endfunction

    // Variable-length quantity in n bytes, padded with leading zero groups.
    function automatic void body_vlq(bit [27:0] v, int n);
        for (int i = n - 1; i >= 0; i--)
            append_body({(i != 0), v[7*i +: 7]});
    endfunction

    function automatic int vlq_bytes(bit [27:0] v);
        int n;
        n = 1;
        while (n < 4 && (v >> (7 * n)) != 0)
            n++;
        return n;
    endfunction

    function automatic void file_header(bit [15:0] ntrk, bit [15:0] div, bit inject);
        bit [31:0] id;
        bit [31:0] len;
        id  = smfp_pkg::ID_MTHD;
        len = 32'd6;
        // Occasionally break the header id or its length.
        if (inject && $urandom_range(0, 39) == 0)
            id[8*$urandom_range(0, 3) +: 8] = 8'($urandom_range(0, 255));
        if (inject && $urandom_range(0, 39) == 0)
            len = $urandom_range(0, 12);
        put_byte(id[31:24], 1'b1);
        put_word(id, 3);
        put_word(len, 4);
        put_word($urandom_range(0, 65535), 2);
        put_word(32'(ntrk), 2);
        put_word(32'(div), 2);
    endfunction

    function automatic bit [7:0] data_byte();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 127));
    endfunction

    // Appends one event to the current track body.
    function automatic void add_event(bit inject);
        bit [27:0] delta;
        bit [7:0]  st;
        bit [7:0]  kind;
        int        len;
        int        sel;
        int        fixed_len[6];
        bit [7:0]  fixed_kind[6];
        fixed_kind = '{8'h00, 8'h2F, 8'h51, 8'h54, 8'h58, 8'h59};
        fixed_len  = '{2, 0, 3, 5, 4, 2};
        case ($urandom_range(0, 3))
            0: delta = '0;
            1: delta = 28'($urandom_range(0, 127));
            2: delta = 28'($urandom & 32'h0FFFFFF);
            default: delta = 28'h0FFFFFFF;
        endcase
        sel = $urandom_range(0, 99);
        if (sel >= 92 && !inject)
            sel = 0;
        if (sel >= 92) begin
            // Faults: overlong delta, unknown system status, bad meta length,
            // or a stray data byte, which faults only where no running status exists.
            case ($urandom_range(0, 3))
                0: begin
                    repeat (4) append_body(8'h80 | 8'($urandom_range(0, 127)));
                    append_body(8'($urandom_range(0, 255)));
                end
                1: begin
                    body_vlq(delta, vlq_bytes(delta));
                    do st = 8'($urandom_range(8'hF1, 8'hFE)); while (st == 8'hF7);
                    append_body(st);
                end
                2: begin
                    body_vlq(delta, vlq_bytes(delta));
                    sel = $urandom_range(0, 5);
                    append_body(8'hFF);
                    append_body(fixed_kind[sel]);
                    body_vlq(28'(fixed_len[sel] + 1), 1);
                end
                default: begin
                    body_vlq(delta, vlq_bytes(delta));
                    last_channel_status = '0;
                    append_body(8'($urandom_range(0, 127)));
                end
            endcase
            return;
        end
        body_vlq(delta, $urandom_range(vlq_bytes(delta), 4));
        if (sel < 50) begin
            if (last_channel_status != 0 && $urandom_range(0, 2) == 0) begin
                st = last_channel_status;
                append_body(8'($urandom_range(0, 127)));
            end else begin
                st = 8'($urandom_range(8'h80, 8'hEF));
                last_channel_status = st;
                append_body(st);
                append_body(data_byte());
            end
            if (has_two_data(st))
                append_body(data_byte());
        end else if (sel < 78) begin
            last_channel_status = '0;
            if ($urandom_range(0, 1) == 0) begin
                sel  = $urandom_range(0, 5);
                kind = fixed_kind[sel];
                len  = fixed_len[sel];
            end else begin
                kind = 8'($urandom_range(0, 255));
                if (kind inside {8'h00, 8'h2F, 8'h51, 8'h54, 8'h58, 8'h59})
                    kind = 8'h7F;
                len = $urandom_range(0, 6);
            end
            append_body(8'hFF);
            append_body(kind);
            body_vlq(28'(len), $urandom_range(1, 2));
            repeat (len) append_body(8'($urandom_range(0, 255)));
        end else begin
            last_channel_status = '0;
            len = $urandom_range(0, 5);
            append_body($urandom_range(0, 1) ? 8'hF0 : 8'hF7);
            body_vlq(28'(len), $urandom_range(1, 2));
            repeat (len) append_body(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void random_file(bit inject);
        int        ntrk;
        bit [15:0] div;
        bit [31:0] id;
        bit [31:0] len;
        ntrk = $urandom_range(0, 6) == 0 ? 0 : $urandom_range(1, 3);
        div  = 16'($urandom_range(0, 32767));
        if (inject && $urandom_range(0, 29) == 0)
            div[15] = 1'b1;
        file_header(16'(ntrk), div, inject);
        for (int t = 0; t < ntrk; t++) begin
            track_body.delete();
            last_channel_status = '0;
            if ($urandom_range(0, 11) != 0)
                repeat ($urandom_range(1, 6)) add_event(inject);
            len = track_body.size();
            // A short length makes the last event run past the chunk.
            if (len > 2 && $urandom_range(0, 14) == 0)
                len = len - $urandom_range(1, 2);
            id = smfp_pkg::ID_MTRK;
            if (inject && $urandom_range(0, 39) == 0)
                id[8*$urandom_range(0, 3) +: 8] = 8'($urandom_range(0, 255));
            put_word(id, 4);
            put_word(len, 4);
            foreach (track_body[i])
                put_byte(track_body[i]);
        end
        // Trailing bytes after the file or after a fault are ignored.
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------
    // Driver: loads the next file byte, with random gaps, when the input slot is free.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_bytes
        file_byte_t fb;
        int         idle_pct;
        int         stage;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            stage    = (bytes_sent * 4) / (bytes_total + 1);
            idle_pct = (stage == 1) ? 53 : (stage == 3) ? 8 : 0;
            if (byte_stream.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                fb = byte_stream.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= fb.value;
                s_tuser  <= fb.first;
                predict_byte(fb.value, fb.first);
                bytes_sent++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stalls follow the same phases as the sender gaps.
    always @(posedge aclk) begin : drive_ready
        int stage;
        int stall_pct;
        stage     = (bytes_sent * 4) / (bytes_total + 1);
        stall_pct = (stage == 2) ? 53 : (stage == 3) ? 8 : 0;
        m_tready <= aresetn && ($urandom_range(0, 99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transaction against the oldest prediction.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, bit [31:0] exp_v, bit [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : check_results
        smfp_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction, kind 0x%0h", m_tuser);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_tuser));
                check_field("track_index", 32'(want.track_index), 32'(m_tdata[15:0]));
                check_field("delta_ticks", 32'(want.delta_ticks), 32'(m_tdata[43:16]));
                check_field("status_byte", 32'(want.status_byte), 32'(m_tdata[51:44]));
                check_field("first_data", 32'(want.first_data), 32'(m_tdata[59:52]));
                check_field("second_data", 32'(want.second_data), 32'(m_tdata[67:60]));
                check_field("meta_kind", 32'(want.meta_kind), 32'(m_tdata[75:68]));
                check_field("body_length", 32'(want.body_length), 32'(m_tdata[103:76]));
                check_field("body_byte", 32'(want.body_byte), 32'(m_tdata[111:104]));
                check_field("error_code", 32'(want.error_code), 32'(m_tdata[114:112]));
                check_field("ticks_per_quarter", 32'(want.ticks_per_quarter),
                            32'(m_tdata[129:115]));
                check_field("file_done", 32'(want.file_done), 32'(m_tlast));
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        mismatch_count = 0;
        cycle_count    = 0;
        bytes_sent     = 0;
        parser_reset();
        // Directed: a file with no tracks at the largest division, then an
        // SMPTE division, then a clean one-track file of channel 16 events,
        // running status and a program change.
        file_header(16'd0, 16'h7FFF, 1'b0);
        file_header(16'd1, 16'hE728, 1'b0);
        file_header(16'd1, 16'h0000, 1'b0);
        put_word(smfp_pkg::ID_MTRK, 4);
        put_word(32'd10, 4);
        put_word(32'h008F7F00, 4);
        put_word(32'h0000405A, 3);
        put_word(32'h00CF05, 3);
        while (byte_stream.size() < 1250)
            random_file(1'b1);
        bytes_total = byte_stream.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_stream.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0 && expected_results.size() == 0 && !m_tvalid) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/smfp_pkg.sv
rtl/core/smfp_parse.sv
rtl/core/smfp_out_reg.sv
rtl/core/midi_file_track_parser.sv
bench/midi_file_track_parser_test.sv
